// ===== design/kdpc_pkg.sv =====
package kdpc_pkg;

  // Debounce state codes.
  localparam logic [1:0] ST_UP       = 2'd0;
  localparam logic [1:0] ST_DOWN_SET = 2'd1;
  localparam logic [1:0] ST_DOWN     = 2'd2;
  localparam logic [1:0] ST_UP_SET   = 2'd3;

  // Press count saturation value.
  localparam logic [7:0] TALLY_MAX = 8'd250;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 1'd1;
  localparam logic [7:0] SETTLE_TIME_RST = 8'd20;
  localparam logic [7:0] TICK_PERIOD_RST = 8'd10;

  typedef struct packed {
    logic do_tick;
    logic pin_level;
    logic clear_count;
    logic ack_change;
  } in_item_t;

  typedef struct packed {
    logic [1:0] key_phase;
    logic       state_changed;
    logic [7:0] press_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0] settle_time_ms;
    logic [7:0] tick_period_ms;
  } cfg_t;

endpackage

// ===== design/kdpc_cfg_regs.sv =====
module kdpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  output kdpc_pkg::cfg_t                cfg
);
  import kdpc_pkg::*;

  cfg_t cfg_r;

  // Register file: one write per cycle, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_time_ms <= SETTLE_TIME_RST;
      cfg_r.tick_period_ms <= TICK_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE_TIME: cfg_r.settle_time_ms <= cfg_wdata;
        CFG_TICK_PERIOD: cfg_r.tick_period_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/kdpc_core.sv =====
module kdpc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  kdpc_pkg::in_item_t  item,
  input  kdpc_pkg::cfg_t      cfg,
  output kdpc_pkg::out_item_t result
);
  import kdpc_pkg::*;

  logic [1:0] state_r,   state_nxt;
  logic [8:0] elapsed_r, elapsed_nxt;
  logic       changed_r, changed_nxt;
  logic [7:0] tally_r,   tally_nxt;

  logic [8:0] elapsed_sum;
  logic       settled;
  logic       changed_rep;

  // Elapsed time is 9 bits wide, so the sum cannot wrap; the threshold is met once it reaches settle time.
  assign elapsed_sum = elapsed_r + {1'b0, cfg.tick_period_ms};
  assign settled     = (elapsed_sum >= {1'b0, cfg.settle_time_ms});

  // One refresh step when do_tick is set, then count clear and flag acknowledge.
  always_comb begin
    state_nxt   = state_r;
    elapsed_nxt = elapsed_r;
    changed_rep = changed_r;
    tally_nxt   = tally_r;
    if (item.do_tick) begin
      case (state_r)
        ST_UP: begin
          if (item.pin_level) begin
            elapsed_nxt = '0;
            state_nxt   = ST_DOWN_SET;
          end
        end
        ST_DOWN_SET: begin
          elapsed_nxt = elapsed_sum;
          if (settled) begin
            if (item.pin_level) begin
              changed_rep = 1'b1;
              state_nxt   = ST_DOWN;
            end else begin
              state_nxt = ST_UP;
            end
          end
        end
        ST_DOWN: begin
          if (!item.pin_level) begin
            elapsed_nxt = '0;
            state_nxt   = ST_UP_SET;
          end
        end
        default: begin
          elapsed_nxt = elapsed_sum;
          if (settled) begin
            if (!item.pin_level) begin
              changed_rep = 1'b1;
              state_nxt   = ST_UP;
              if (tally_r < TALLY_MAX) begin
                tally_nxt = tally_r + 8'd1;
              end
            end else begin
              state_nxt = ST_DOWN;
            end
          end
        end
      endcase
    end
    if (item.clear_count) begin
      tally_nxt = '0;
    end
    changed_nxt = changed_rep & ~item.ack_change;
  end

  // The result reports the flag before the acknowledge takes effect.
  assign result.key_phase     = state_nxt;
  assign result.state_changed = changed_rep;
  assign result.press_count   = tally_nxt;

  // State advances only when an item moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_UP;
      elapsed_r <= '0;
      changed_r <= 1'b0;
      tally_r   <= '0;
    end else if (step) begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
      changed_r <= changed_nxt;
      tally_r   <= tally_nxt;
    end
  end

endmodule

// ===== design/key_debounce_press_counter.sv =====
// A result passes the input register, then the result register, and waits in
// either one while out_ready is low and the result register is full.
// Throughput: one item per cycle while the output is not stalled; the debounce state updates
// as an item moves from the input register to the result register.
// Reset (rst_n, synchronous, active low): key up, elapsed time, changed flag
// and press count cleared, settle time 20 ms, tick period 10 ms.
module key_debounce_press_counter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  kdpc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output kdpc_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [kdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata
);
  import kdpc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t result;
  logic      step;

  kdpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // An item moves on when the result register is empty or being drained.
  assign step     = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | step;

  kdpc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
